@@ rtl/watershed_from_gray_marker_core_defines.svh @@
// Assertion macros shared by the watershed core.
`ifndef WATERSHED_FROM_GRAY_MARKER_CORE_DEFINES_SVH
`define WATERSHED_FROM_GRAY_MARKER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define WGM_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("watershed core check failed");

// Next-cycle implication, checked outside reset.
`define WGM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("watershed core check failed");

`endif

@@ rtl/wgm_pkg.sv @@
// Types, codes and the neighbor offset table of the watershed core.
package wgm_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_CLRB,
        ST_INIT_RD,
        ST_INIT_B,
        ST_INS_WR,
        ST_INS_LINK,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_P_RD,
        ST_P_UL,
        ST_NB_SET,
        ST_NB_EVAL,
        ST_UQ_RD,
        ST_UQ_WR,
        ST_CONQ
    } state_t;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_MODE   = 2'd2;

    localparam logic MODE_FOUR  = 1'b0;
    localparam logic MODE_EIGHT = 1'b1;

    localparam logic [3:0] NBR4_COUNT = 4'd4;
    localparam logic [3:0] NBR8_COUNT = 4'd8;

    localparam logic [1:0] STEP_NEG  = 2'b11;
    localparam logic [1:0] STEP_ZERO = 2'b00;
    localparam logic [1:0] STEP_POS  = 2'b01;

    typedef struct packed {
        logic [1:0] dx;
        logic [1:0] dy;
    } nbr_off_t;

    function automatic nbr_off_t nbr_offset(input logic mode, input logic [3:0] k);
        logic [2:0] idx;
        nbr_off_t o;
        if (mode == MODE_EIGHT) begin
            idx = k[2:0];
        end else begin
            unique case (k[1:0])
                2'd0: idx = 3'd1;
                2'd1: idx = 3'd3;
                2'd2: idx = 3'd4;
                default: idx = 3'd6;
            endcase
        end
        unique case (idx)
            3'd0: o = '{dx: STEP_NEG,  dy: STEP_NEG};
            3'd1: o = '{dx: STEP_ZERO, dy: STEP_NEG};
            3'd2: o = '{dx: STEP_POS,  dy: STEP_NEG};
            3'd3: o = '{dx: STEP_NEG,  dy: STEP_ZERO};
            3'd4: o = '{dx: STEP_POS,  dy: STEP_ZERO};
            3'd5: o = '{dx: STEP_NEG,  dy: STEP_POS};
            3'd6: o = '{dx: STEP_ZERO, dy: STEP_POS};
            default: o = '{dx: STEP_POS,  dy: STEP_POS};
        endcase
        return o;
    endfunction

endpackage

@@ rtl/wgm_nbr.sv @@
// Neighbor address unit: bounds check and raster address of one neighbor.
module wgm_nbr import wgm_pkg::*; #(
    parameter int IDXW = 16,
    parameter int XW   = 8,
    parameter int YW   = 8,
    parameter int WW   = 9,
    parameter int HW   = 9
) (
    input  logic [IDXW-1:0] p,
    input  logic [XW-1:0]   x,
    input  logic [YW-1:0]   y,
    input  logic [WW-1:0]   wcol,
    input  logic [HW-1:0]   hrow,
    input  logic            mode,
    input  logic [3:0]      k,
    output logic            in_image,
    output logic [IDXW-1:0] q
);

    nbr_off_t        off;
    logic [IDXW-1:0] wq;
    logic [IDXW-1:0] row_base;

    always_comb begin
        off = nbr_offset(mode, k);
        wq  = IDXW'(wcol);
        in_image = !((off.dx == STEP_NEG) && (x == '0))
                && !((off.dx == STEP_POS) && ((WW'(x) + WW'(1)) == wcol))
                && !((off.dy == STEP_NEG) && (y == '0))
                && !((off.dy == STEP_POS) && ((HW'(y) + HW'(1)) == hrow));
        if (off.dy == STEP_NEG) begin
            row_base = p - wq;
        end else if (off.dy == STEP_POS) begin
            row_base = p + wq;
        end else begin
            row_base = p;
        end
        if (off.dx == STEP_NEG) begin
            q = row_base - IDXW'(1);
        end else if (off.dx == STEP_POS) begin
            q = row_base + IDXW'(1);
        end else begin
            q = row_base;
        end
    end

endmodule

@@ rtl/watershed_from_gray_marker_core.sv @@
// Top level of the watershed core: image stores, bucket queue and sequencer.
// Load request: written to the stores on acceptance. Read request: the label store is read and
// the result is registered at the output once the output register is free. Compute after the
// last load: a bucket clearing pass over all 2**MARKER_BITS+2 buckets, queueing of each pixel,
// then per dequeued pixel a scan over empty buckets, a visit to each neighbor and any relabels.
// Reset (aresetn, synchronous) clears control state and configuration; datapath registers and stores keep data.
`include "watershed_from_gray_marker_core_defines.svh"
module watershed_from_gray_marker_core import wgm_pkg::*; #(
    parameter int MAX_COLS    = 256,
    parameter int MAX_ROWS    = 256,
    parameter int PIXEL_BITS  = 8,
    parameter int MARKER_BITS = 9
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // pixel_index[15:0], gradient_value[23:16], marker_value[32:24]
    input  logic        s_tuser,  // req_type
    input  logic        s_tlast,  // last_pixel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata   // region_label[16:0], label_index[32:17]
);

    localparam int NPIX  = MAX_COLS * MAX_ROWS;
    localparam int IDXW  = $clog2(NPIX);
    localparam int LW    = IDXW + 1;
    localparam int NW    = IDXW + 1;
    localparam int XW    = $clog2(MAX_COLS);
    localparam int YW    = $clog2(MAX_ROWS);
    localparam int WW    = $clog2(MAX_COLS + 1);
    localparam int HW    = $clog2(MAX_ROWS + 1);
    localparam int CB    = (MARKER_BITS + 1 > PIXEL_BITS) ? MARKER_BITS + 1 : PIXEL_BITS;
    localparam int NBUCK = (1 << MARKER_BITS) + 2;
    localparam int BW    = $clog2(NBUCK);
    localparam int MBW   = $clog2(NBUCK + 1);
    localparam int BKW   = 1 + 2 * IDXW;
    localparam int CW    = XW + YW;
    localparam logic [LW-1:0] LINK_NONE = {1'b1, {IDXW{1'b0}}};

    function automatic logic [BW-1:0] bucket_of(input logic [CB-1:0] c);
        logic [31:0] cx;
        cx = 32'(c);
        return (cx >= 32'(NBUCK)) ? BW'(NBUCK - 1) : cx[BW-1:0];
    endfunction

    // Stores.
    logic [PIXEL_BITS-1:0] grad_mem  [NPIX];
    logic [CB-1:0]         cost_mem  [NPIX];
    logic [16:0]           label_mem [NPIX];
    logic                  pred_mem  [NPIX];
    logic                  inq_mem   [NPIX];
    logic [LW-1:0]         prev_mem  [NPIX];
    logic [LW-1:0]         next_mem  [NPIX];
    logic [CW-1:0]         coord_mem [NPIX];
    logic [BKW-1:0]        bkt_mem   [NBUCK];

    logic                  g_we, c_we, l_we, pr_we, iq_we, pv_we, nx_we, co_we, bk_we;
    logic [IDXW-1:0]       g_wa, c_wa, l_wa, pr_wa, iq_wa, pv_wa, nx_wa, co_wa;
    logic [IDXW-1:0]       g_ra, c_ra, l_ra, pr_ra, iq_ra, pv_ra, nx_ra, co_ra;
    logic [BW-1:0]         bk_wa, bk_ra;
    logic [PIXEL_BITS-1:0] g_wd;
    logic [CB-1:0]         c_wd;
    logic [16:0]           l_wd;
    logic                  pr_wd, iq_wd;
    logic [LW-1:0]         pv_wd, nx_wd;
    logic [CW-1:0]         co_wd;
    logic [BKW-1:0]        bk_wd;

    logic [PIXEL_BITS-1:0] grad_rd_reg;
    logic [CB-1:0]         cost_rd_reg;
    logic [16:0]           label_rd_reg;
    logic                  pred_rd_reg, inq_rd_reg;
    logic [LW-1:0]         prev_rd_reg, next_rd_reg;
    logic [CW-1:0]         coord_rd_reg;
    logic [BKW-1:0]        bkt_rd_reg;

    always_ff @(posedge aclk) begin
        if (g_we) grad_mem[g_wa] <= g_wd;
        grad_rd_reg <= grad_mem[g_ra];
    end
    always_ff @(posedge aclk) begin
        if (c_we) cost_mem[c_wa] <= c_wd;
        cost_rd_reg <= cost_mem[c_ra];
    end
    always_ff @(posedge aclk) begin
        if (l_we) label_mem[l_wa] <= l_wd;
        label_rd_reg <= label_mem[l_ra];
    end
    always_ff @(posedge aclk) begin
        if (pr_we) pred_mem[pr_wa] <= pr_wd;
        pred_rd_reg <= pred_mem[pr_ra];
    end
    always_ff @(posedge aclk) begin
        if (iq_we) inq_mem[iq_wa] <= iq_wd;
        inq_rd_reg <= inq_mem[iq_ra];
    end
    always_ff @(posedge aclk) begin
        if (pv_we) prev_mem[pv_wa] <= pv_wd;
        prev_rd_reg <= prev_mem[pv_ra];
    end
    always_ff @(posedge aclk) begin
        if (nx_we) next_mem[nx_wa] <= nx_wd;
        next_rd_reg <= next_mem[nx_ra];
    end
    always_ff @(posedge aclk) begin
        if (co_we) coord_mem[co_wa] <= co_wd;
        coord_rd_reg <= coord_mem[co_ra];
    end
    always_ff @(posedge aclk) begin
        if (bk_we) bkt_mem[bk_wa] <= bk_wd;
        bkt_rd_reg <= bkt_mem[bk_ra];
    end

    // Control and working registers.
    state_t          state_reg, state_next;
    logic [8:0]      width_cfg_reg, height_cfg_reg;
    logic            mode_reg;
    logic [WW-1:0]   wcol_reg, wcol_next;
    logic [HW-1:0]   hrow_reg, hrow_next;
    logic [NW-1:0]   npix_reg, npix_next;
    logic [BW-1:0]   cnt_reg, cnt_next;
    logic [IDXW-1:0] p_reg, p_next;
    logic [XW-1:0]   ix_reg, ix_next, xp_reg, xp_next;
    logic [YW-1:0]   iy_reg, iy_next, yp_reg, yp_next;
    logic            in_init_reg, in_init_next;
    logic [MBW-1:0]  min_b_reg, min_b_next;
    logic [16:0]     next_label_reg, next_label_next;
    logic [IDXW-1:0] ptail_reg, ptail_next;
    logic [CB-1:0]   cp_reg, cp_next, tmp_reg, tmp_next;
    logic [16:0]     labp_reg, labp_next;
    logic [3:0]      k_reg, k_next;
    logic [IDXW-1:0] q_reg, q_next;
    logic [LW-1:0]   qpv_reg, qpv_next, qnx_reg, qnx_next;
    logic [BW-1:0]   bq_reg, bq_next, ins_b_reg, ins_b_next;
    logic [IDXW-1:0] ins_x_reg, ins_x_next, otail_reg, otail_next;
    logic [15:0]     ridx_reg, ridx_next;
    logic            roob_reg, roob_next;
    logic            m_valid_reg, m_valid_next;
    logic [16:0]     m_label_reg, m_label_next;
    logic [15:0]     m_index_reg, m_index_next;

    // Request fields and derived conditions.
    logic            s_acc;
    logic [15:0]     in_idx;
    logic [7:0]      in_grad;
    logic [8:0]      in_marker;
    logic            in_range;
    logic [IDXW-1:0] in_addr;
    logic [WW-1:0]   wcl;
    logic [HW-1:0]   hcl;
    logic            init_last, k_end, scan_end, out_free;
    logic            bk_valid;
    logic [IDXW-1:0] bk_head, bk_tail;
    logic [CB-1:0]   tmp_c;
    logic            conquer;
    logic            nb_inside;
    logic [IDXW-1:0] nb_q;
    state_t          ret_state;

    assign s_acc     = s_tvalid && s_tready;
    assign in_idx    = s_tdata[15:0];
    assign in_grad   = s_tdata[23:16];
    assign in_marker = s_tdata[32:24];
    assign in_range  = 32'(in_idx) < 32'(NPIX);
    assign in_addr   = IDXW'(in_idx);

    assign wcl = (width_cfg_reg == '0) ? WW'(1)
               : (32'(width_cfg_reg) > 32'(MAX_COLS)) ? WW'(MAX_COLS) : WW'(width_cfg_reg);
    assign hcl = (height_cfg_reg == '0) ? HW'(1)
               : (32'(height_cfg_reg) > 32'(MAX_ROWS)) ? HW'(MAX_ROWS) : HW'(height_cfg_reg);

    assign init_last = (NW'(p_reg) + NW'(1)) == npix_reg;
    assign k_end     = k_reg == ((mode_reg == MODE_EIGHT) ? NBR8_COUNT : NBR4_COUNT);
    assign scan_end  = min_b_reg == MBW'(NBUCK);
    assign out_free  = !m_valid_reg || m_tready;
    assign bk_valid  = bkt_rd_reg[BKW-1];
    assign bk_head   = bkt_rd_reg[BKW-2:IDXW];
    assign bk_tail   = bkt_rd_reg[IDXW-1:0];
    assign tmp_c     = (cp_reg > CB'(grad_rd_reg)) ? cp_reg : CB'(grad_rd_reg);
    assign conquer   = (cost_rd_reg > cp_reg) && (tmp_c < cost_rd_reg);
    assign ret_state = in_init_reg ? (init_last ? ST_SCAN_RD : ST_INIT_RD) : ST_NB_SET;

    wgm_nbr #(
        .IDXW(IDXW), .XW(XW), .YW(YW), .WW(WW), .HW(HW)
    ) u_nbr (
        .p(p_reg), .x(xp_reg), .y(yp_reg), .wcol(wcol_reg), .hrow(hrow_reg),
        .mode(mode_reg), .k(k_reg), .in_image(nb_inside), .q(nb_q)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {7'd0, m_index_reg, m_label_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= 9'd256;
            height_cfg_reg <= 9'd256;
            mode_reg       <= MODE_FOUR;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_WIDTH:  width_cfg_reg  <= cfg_data;
                CFG_HEIGHT: height_cfg_reg <= cfg_data;
                CFG_MODE:   mode_reg       <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (s_tuser == REQ_READ) state_next = ST_READ;
                    else if (s_tlast) state_next = ST_CLRB;
                end
            end
            ST_READ:     if (out_free) state_next = ST_IDLE;
            ST_CLRB:     if (cnt_reg == BW'(NBUCK - 1)) state_next = ST_INIT_RD;
            ST_INIT_RD:  state_next = ST_INIT_B;
            ST_INIT_B:   state_next = ST_INS_WR;
            ST_INS_WR:   state_next = bk_valid ? ST_INS_LINK : ret_state;
            ST_INS_LINK: state_next = ret_state;
            ST_SCAN_RD:  state_next = scan_end ? ST_IDLE : ST_SCAN_CHK;
            ST_SCAN_CHK: state_next = bk_valid ? ST_P_RD : ST_SCAN_RD;
            ST_P_RD:     state_next = ST_P_UL;
            ST_P_UL:     state_next = ST_NB_SET;
            ST_NB_SET: begin
                if (k_end) state_next = ST_SCAN_RD;
                else if (nb_inside) state_next = ST_NB_EVAL;
            end
            ST_NB_EVAL: begin
                if (conquer) state_next = inq_rd_reg ? ST_UQ_RD : ST_CONQ;
                else state_next = ST_NB_SET;
            end
            ST_UQ_RD:    state_next = ST_UQ_WR;
            ST_UQ_WR:    state_next = ST_CONQ;
            ST_CONQ:     state_next = ST_INS_WR;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath and store control.
    always_comb begin
        wcol_next = wcol_reg;  hrow_next = hrow_reg;  npix_next = npix_reg;
        cnt_next = cnt_reg;    p_next = p_reg;        ix_next = ix_reg;  iy_next = iy_reg;
        xp_next = xp_reg;      yp_next = yp_reg;      in_init_next = in_init_reg;
        min_b_next = min_b_reg;  next_label_next = next_label_reg;
        ptail_next = ptail_reg;  cp_next = cp_reg;    tmp_next = tmp_reg;
        labp_next = labp_reg;  k_next = k_reg;        q_next = q_reg;
        qpv_next = qpv_reg;    qnx_next = qnx_reg;    bq_next = bq_reg;
        ins_b_next = ins_b_reg;  ins_x_next = ins_x_reg;  otail_next = otail_reg;
        ridx_next = ridx_reg;  roob_next = roob_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_label_next = m_label_reg;  m_index_next = m_index_reg;

        g_we = 1'b0;  c_we = 1'b0;  l_we = 1'b0;  pr_we = 1'b0;  iq_we = 1'b0;
        pv_we = 1'b0; nx_we = 1'b0; co_we = 1'b0; bk_we = 1'b0;
        g_wa = '0;  c_wa = '0;  l_wa = '0;  pr_wa = '0;  iq_wa = '0;
        pv_wa = '0; nx_wa = '0; co_wa = '0; bk_wa = '0;
        g_ra = '0;  c_ra = '0;  l_ra = '0;  pr_ra = '0;  iq_ra = '0;
        pv_ra = '0; nx_ra = '0; co_ra = '0; bk_ra = '0;
        g_wd = '0;  c_wd = '0;  l_wd = '0;  pr_wd = 1'b0;  iq_wd = 1'b0;
        pv_wd = '0; nx_wd = '0; co_wd = '0; bk_wd = '0;

        unique case (state_reg)
            ST_IDLE: begin
                l_ra = in_addr;
                if (s_acc) begin
                    if (s_tuser == REQ_READ) begin
                        ridx_next = in_idx;
                        roob_next = !in_range;
                    end else begin
                        g_we = in_range;  g_wa = in_addr;  g_wd = PIXEL_BITS'(in_grad);
                        c_we = in_range;  c_wa = in_addr;
                        c_wd = CB'(MARKER_BITS'(in_marker)) + CB'(1);
                        if (s_tlast) begin
                            wcol_next = wcl;
                            hrow_next = hcl;
                            cnt_next  = '0;
                        end
                    end
                end
            end
            ST_READ: begin
                l_ra = IDXW'(ridx_reg);
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_label_next = roob_reg ? 17'd0 : label_rd_reg;
                    m_index_next = ridx_reg;
                end
            end
            ST_CLRB: begin
                bk_we = 1'b1;  bk_wa = cnt_reg;  bk_wd = '0;
                cnt_next  = cnt_reg + BW'(1);
                npix_next = NW'(wcol_reg) * NW'(hrow_reg);
                p_next = '0;  ix_next = '0;  iy_next = '0;
                in_init_next = 1'b1;  min_b_next = '0;  next_label_next = 17'd1;
            end
            ST_INIT_RD: begin
                c_ra = p_reg;
                pr_we = 1'b1;  pr_wa = p_reg;  pr_wd = 1'b0;
                co_we = 1'b1;  co_wa = p_reg;  co_wd = {iy_reg, ix_reg};
                ins_x_next = p_reg;
            end
            ST_INIT_B: begin
                bk_ra = bucket_of(cost_rd_reg);
                ins_b_next = bucket_of(cost_rd_reg);
            end
            ST_INS_WR, ST_INS_LINK: begin
                if (state_reg == ST_INS_WR) begin
                    pv_we = 1'b1;  pv_wa = ins_x_reg;
                    pv_wd = bk_valid ? {1'b0, bk_tail} : LINK_NONE;
                    nx_we = 1'b1;  nx_wa = ins_x_reg;  nx_wd = LINK_NONE;
                    bk_we = 1'b1;  bk_wa = ins_b_reg;
                    bk_wd = {1'b1, (bk_valid ? bk_head : ins_x_reg), ins_x_reg};
                    iq_we = 1'b1;  iq_wa = ins_x_reg;  iq_wd = 1'b1;
                    otail_next = bk_tail;
                    if (MBW'(ins_b_reg) < min_b_reg) min_b_next = MBW'(ins_b_reg);
                end else begin
                    nx_we = 1'b1;  nx_wa = otail_reg;  nx_wd = {1'b0, ins_x_reg};
                end
                if (state_reg == ST_INS_LINK || !bk_valid) begin
                    if (in_init_reg) begin
                        if (init_last) begin
                            in_init_next = 1'b0;
                        end else begin
                            p_next = p_reg + IDXW'(1);
                            if ((WW'(ix_reg) + WW'(1)) == wcol_reg) begin
                                ix_next = '0;
                                iy_next = iy_reg + YW'(1);
                            end else begin
                                ix_next = ix_reg + XW'(1);
                            end
                        end
                    end else begin
                        k_next = k_reg + 4'd1;
                    end
                end
            end
            ST_SCAN_RD: begin
                bk_ra = min_b_reg[BW-1:0];
            end
            ST_SCAN_CHK: begin
                if (bk_valid) begin
                    p_next = bk_head;
                    ptail_next = bk_tail;
                end else begin
                    min_b_next = min_b_reg + MBW'(1);
                end
            end
            ST_P_RD: begin
                c_ra = p_reg;  g_ra = p_reg;  l_ra = p_reg;  pr_ra = p_reg;
                pv_ra = p_reg; nx_ra = p_reg; co_ra = p_reg;
            end
            ST_P_UL: begin
                bk_we = 1'b1;  bk_wa = min_b_reg[BW-1:0];
                bk_wd = {!next_rd_reg[LW-1], next_rd_reg[IDXW-1:0], ptail_reg};
                pv_we = !next_rd_reg[LW-1];  pv_wa = next_rd_reg[IDXW-1:0];  pv_wd = LINK_NONE;
                iq_we = 1'b1;  iq_wa = p_reg;  iq_wd = 1'b0;
                xp_next = coord_rd_reg[XW-1:0];
                yp_next = coord_rd_reg[CW-1:XW];
                k_next = '0;
                if (pred_rd_reg) begin
                    cp_next = cost_rd_reg;
                    labp_next = label_rd_reg;
                end else begin
                    cp_next = CB'(grad_rd_reg);
                    labp_next = next_label_reg;
                    c_we = 1'b1;  c_wa = p_reg;  c_wd = CB'(grad_rd_reg);
                    l_we = 1'b1;  l_wa = p_reg;  l_wd = next_label_reg;
                    next_label_next = next_label_reg + 17'd1;
                end
            end
            ST_NB_SET: begin
                c_ra = nb_q;  g_ra = nb_q;  iq_ra = nb_q;  pv_ra = nb_q;  nx_ra = nb_q;
                if (!k_end) begin
                    if (nb_inside) q_next = nb_q;
                    else k_next = k_reg + 4'd1;
                end
            end
            ST_NB_EVAL: begin
                if (conquer) begin
                    tmp_next = tmp_c;
                    qpv_next = prev_rd_reg;
                    qnx_next = next_rd_reg;
                    bq_next  = bucket_of(cost_rd_reg);
                end else begin
                    k_next = k_reg + 4'd1;
                end
            end
            ST_UQ_RD: begin
                bk_ra = bq_reg;
            end
            ST_UQ_WR: begin
                nx_we = !qpv_reg[LW-1];  nx_wa = qpv_reg[IDXW-1:0];  nx_wd = qnx_reg;
                pv_we = !qnx_reg[LW-1];  pv_wa = qnx_reg[IDXW-1:0];  pv_wd = qpv_reg;
                bk_we = 1'b1;  bk_wa = bq_reg;
                bk_wd = {!(qpv_reg[LW-1] && qnx_reg[LW-1]),
                         (qpv_reg[LW-1] ? qnx_reg[IDXW-1:0] : bk_head),
                         (qnx_reg[LW-1] ? qpv_reg[IDXW-1:0] : bk_tail)};
            end
            ST_CONQ: begin
                pr_we = 1'b1;  pr_wa = q_reg;  pr_wd = 1'b1;
                l_we  = 1'b1;  l_wa  = q_reg;  l_wd  = labp_reg;
                c_we  = 1'b1;  c_wa  = q_reg;  c_wd  = tmp_reg;
                bk_ra = bucket_of(tmp_reg);
                ins_b_next = bucket_of(tmp_reg);
                ins_x_next = q_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            min_b_reg      <= '0;
            next_label_reg <= 17'd1;
            in_init_reg    <= 1'b0;
            k_reg          <= '0;
            cnt_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            min_b_reg      <= min_b_next;
            next_label_reg <= next_label_next;
            in_init_reg    <= in_init_next;
            k_reg          <= k_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        wcol_reg  <= wcol_next;   hrow_reg  <= hrow_next;   npix_reg  <= npix_next;
        p_reg     <= p_next;      ix_reg    <= ix_next;     iy_reg    <= iy_next;
        xp_reg    <= xp_next;     yp_reg    <= yp_next;     ptail_reg <= ptail_next;
        cp_reg    <= cp_next;     tmp_reg   <= tmp_next;    labp_reg  <= labp_next;
        q_reg     <= q_next;      qpv_reg   <= qpv_next;    qnx_reg   <= qnx_next;
        bq_reg    <= bq_next;     ins_b_reg <= ins_b_next;  ins_x_reg <= ins_x_next;
        otail_reg <= otail_next;  ridx_reg  <= ridx_next;   roob_reg  <= roob_next;
        m_label_reg <= m_label_next;
        m_index_reg <= m_index_next;
    end

    // A dequeued pixel is always a bucket head, so it has no queue predecessor.
    `WGM_ASSERT_NOW(a_head_no_prev, state_reg == ST_P_UL, prev_rd_reg[LW-1])
    `WGM_ASSERT_NOW(a_min_bucket_range, 1'b1, min_b_reg <= MBW'(NBUCK))
    `WGM_ASSERT_NEXT(a_read_result, (state_reg == ST_READ) && out_free, m_tvalid && s_tready)

endmodule
